### hw/rtl/lscc_pkg.sv
package lscc_pkg;

  localparam int CHANNELS  = 16;
  localparam int CHAN_W    = 4;
  localparam int SAMPLE_W  = 10;
  localparam int ACT_W     = 2;
  localparam int MIN_W     = 11;
  localparam int MAX_W     = 10;
  localparam int THR_W     = 10;
  localparam int COUNT_W   = 5;
  localparam int MAP_W     = 21;
  localparam int MAG_W     = 20;
  localparam int DEN_W     = 11;
  localparam int DIFF_W    = 12;
  localparam int DIV_STEPS = MAG_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [MIN_W-1:0]   MIN_RESET       = 11'd1024;
  localparam logic [MAX_W-1:0]   MAX_RESET       = 10'd0;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 10'd500;
  localparam logic [COUNT_W-1:0] COUNT_LIMIT     = 5'd31;
  localparam logic [9:0]         MAP_TOP         = 10'd1023;

  localparam logic REG_THRESHOLD = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_CALIBRATE = 2'd0,
    ACT_MEASURE   = 2'd1,
    ACT_CLEAR     = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [MAG_W-1:0] quotient;
  } div_stat_t;

endpackage

### hw/rtl/lscc_div.sv
module lscc_div (
  input  logic               clk,
  input  logic               rst,
  input  lscc_pkg::div_req_t req,
  output lscc_pkg::div_stat_t stat
);
  import lscc_pkg::*;

  logic [MAG_W-1:0]  dvd;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dsr;
  logic [STEP_W-1:0] cnt;
  logic              run;
  logic              done;
  logic [DEN_W:0]    partial;
  logic [DEN_W:0]    trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  always_comb begin
    partial = {rem, dvd[MAG_W-1]};
    trial   = partial - {1'b0, dsr};
    fits    = partial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == STEP_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      dsr <= req.divisor;
      rem <= '0;
    end else if (run) begin
      rem <= fits ? trial[DEN_W-1:0] : partial[DEN_W-1:0];
      dvd <= {dvd[MAG_W-2:0], fits};
    end
  end

  assign stat.busy     = run;
  assign stat.done     = done;
  assign stat.quotient = dvd;

endmodule

### hw/rtl/line_sensor_calibrate_count.sv
// line_sensor_calibrate_count
// flow: each item is accepted in ST_IDLE and its result is loaded into the output register in ST_HOLD;
//   measure items with a nonzero span pass through ST_DIV first (bit-serial divider for the span division)
// one item at a time: s_tready stays low until the result of the last item has been loaded
// rst (synchronous): threshold 500, all channels min 1024 / max 0, sweep count 0
module line_sensor_calibrate_count (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // channel[3:0], sample[13:4], zero fill
  input  logic [1:0]  s_tuser,   // action[1:0]
  input  logic        s_tlast,   // sweep_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // mapped_value[20:0], on_line[21], line_count[26:22], zero fill
  output logic        m_tuser,   // zero_span
  output logic        m_tlast,   // sweep_done
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lscc_pkg::*;

  state_t state, state_next;

  logic [MIN_W-1:0]   ch_min [CHANNELS];
  logic [MAX_W-1:0]   ch_max [CHANNELS];
  logic [THR_W-1:0]   threshold;
  logic [COUNT_W-1:0] sweep_count;

  logic               res_measure;
  logic               res_flat;
  logic               res_neg;
  logic               res_done;
  logic [MAG_W-1:0]   res_mag;

  div_req_t  div_req;
  div_stat_t div_st;

  logic                accept;
  logic                load_out;
  logic                cfg_write;
  action_t             act;
  logic [CHAN_W-1:0]   ch;
  logic [SAMPLE_W-1:0] smp;
  logic                chan_ok;
  logic [MIN_W-1:0]    lo;
  logic [MAX_W-1:0]    hi;
  logic [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]   span;
  logic [DEN_W-1:0]    diff_mag;
  logic [DEN_W-1:0]    span_mag;
  logic [MAG_W-1:0]    num_mag;
  logic                flat;
  logic                hit;
  logic [MAP_W-1:0]    mapped;
  logic [COUNT_W-1:0]  count_new;

  assign act     = action_t'(s_tuser);
  assign ch      = s_tdata[3:0];
  assign smp     = s_tdata[13:4];
  assign chan_ok = 32'(ch) < CHANNELS;
  assign accept  = s_tvalid && s_tready;

  always_comb begin
    lo       = ch_min[ch];
    hi       = ch_max[ch];
    diff     = {2'b00, smp} - {1'b0, lo};
    span     = {2'b00, hi} - {1'b0, lo};
    diff_mag = diff[DIFF_W-1] ? DEN_W'(-diff) : diff[DEN_W-1:0];
    span_mag = span[DIFF_W-1] ? DEN_W'(-span) : span[DEN_W-1:0];
    num_mag  = MAG_W'(diff_mag) * MAG_W'(MAP_TOP);
    flat     = !chan_ok || ({1'b0, hi} == lo);
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (act == ACT_MEASURE && !flat) ? ST_DIV : ST_HOLD;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready         = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = num_mag;
    div_req.divisor  = span_mag;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        div_req.start = s_tvalid && act == ACT_MEASURE && !flat;
      end
      ST_DIV: begin
      end
      ST_HOLD: begin
        load_out = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  lscc_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .stat (div_st)
  );

  // calibration store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CHANNELS; k++) begin
        ch_min[k] <= MIN_RESET;
        ch_max[k] <= MAX_RESET;
      end
    end else if (accept) begin
      case (act)
        ACT_CALIBRATE: begin
          if (chan_ok) begin
            if ({1'b0, smp} < lo) begin
              ch_min[ch] <= {1'b0, smp};
            end
            if (smp > hi) begin
              ch_max[ch] <= smp;
            end
          end
        end
        ACT_CLEAR: begin
          for (int k = 0; k < CHANNELS; k++) begin
            ch_min[k] <= MIN_RESET;
            ch_max[k] <= MAX_RESET;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // pending result
  always_ff @(posedge clk) begin
    if (accept) begin
      res_measure <= act == ACT_MEASURE;
      res_flat    <= act == ACT_MEASURE && flat;
      res_neg     <= diff[DIFF_W-1] ^ span[DIFF_W-1];
      res_done    <= act == ACT_MEASURE && s_tlast;
      res_mag     <= '0;
    end else if (div_st.done) begin
      res_mag <= div_st.quotient;
    end
  end

  always_comb begin
    mapped    = res_neg ? -{1'b0, res_mag} : {1'b0, res_mag};
    hit       = res_measure && !res_neg && (res_mag > MAG_W'(threshold));
    count_new = (hit && sweep_count != COUNT_LIMIT) ? sweep_count + 1'b1 : sweep_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_count <= '0;
    end else if (load_out) begin
      sweep_count <= res_done ? '0 : count_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {5'b0, count_new, hit, mapped};
      m_tuser <= res_flat;
      m_tlast <= res_done;
    end
  end

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && paddr[2] == REG_THRESHOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= pwdata[THR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_THRESHOLD) ? {22'b0, threshold} : 32'b0;

  a_flat_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[20:0] == 21'd0 && !m_tdata[21]))
    else $error("zero span result carries a nonzero mapping");

  a_hit_positive: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[21]) |-> !m_tdata[20])
    else $error("on line flag with a negative mapped value");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == ST_DIV)
    else $error("divider finished outside of the divide state");

  a_busy_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.busy |-> state == ST_DIV)
    else $error("divider running outside of the divide state");

  a_sweep_clear: assert property (@(posedge clk) disable iff (rst)
    (load_out && res_done) |=> sweep_count == '0)
    else $error("sweep count not cleared after the last request of a sweep");

endmodule

### tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lscc_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 360;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic [MAP_W-1:0]   mapped_value;
    logic               on_line;
    logic [COUNT_W-1:0] line_count;
    logic               sweep_done;
    logic               zero_span;
  } reading_t;

  typedef struct packed {
    logic [ACT_W-1:0]    act;
    logic [CHAN_W-1:0]   chan;
    logic [SAMPLE_W-1:0] sample;
    logic                tail;
    logic                typed;
    reading_t            want;
  } sensor_row_t;

  localparam sensor_row_t DIRECTED_ROWS [19] = '{
    '{ACT_MEASURE,   4'd0,  10'd0,    1'b0, 1'b1, '{21'd1023, 1'b1, 5'd1, 1'b0, 1'b0}},
    '{ACT_MEASURE,   4'd15, 10'd1023, 1'b1, 1'b1, '{21'd0, 1'b0, 5'd1, 1'b1, 1'b0}},
    '{ACT_CLEAR,     4'd0,  10'd0,    1'b0, 1'b1, '0},
    '{ACT_UNUSED,    4'd5,  10'd1023, 1'b1, 1'b1, '0},
    '{ACT_CALIBRATE, 4'd3,  10'd1023, 1'b0, 1'b1, '0},
    '{ACT_MEASURE,   4'd3,  10'd1023, 1'b1, 1'b1, '{21'd0, 1'b0, 5'd0, 1'b1, 1'b1}},
    '{ACT_CALIBRATE, 4'd3,  10'd0,    1'b1, 1'b1, '0},
    '{ACT_MEASURE,   4'd3,  10'd0,    1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd3,  10'd1023, 1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd3,  10'd512,  1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd3,  10'd500,  1'b1, 1'b0, '0},
    '{ACT_CALIBRATE, 4'd7,  10'd600,  1'b0, 1'b0, '0},
    '{ACT_CALIBRATE, 4'd7,  10'd400,  1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd7,  10'd1023, 1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd7,  10'd0,    1'b1, 1'b0, '0},
    '{ACT_CLEAR,     4'd9,  10'd1023, 1'b1, 1'b0, '0},
    '{ACT_MEASURE,   4'd7,  10'd300,  1'b0, 1'b0, '0},
    '{ACT_CALIBRATE, 4'd10, 10'd341,  1'b0, 1'b0, '0},
    '{ACT_MEASURE,   4'd10, 10'd682,  1'b1, 1'b0, '0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // channel[3:0], sample[13:4], zero fill
  logic [1:0]  s_tuser = '0;   // action[1:0]
  logic        s_tlast = 1'b0; // sweep_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // mapped_value[20:0], on_line[21], line_count[26:22], zero fill
  logic        m_tuser;        // zero_span
  logic        m_tlast;        // sweep_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  line_sensor_calibrate_count dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [THR_W-1:0]   line_thr;
  logic [MIN_W-1:0]   cal_min [CHANNELS];
  logic [MAX_W-1:0]   cal_max [CHANNELS];
  logic [COUNT_W-1:0] sweep_total;

  reading_t expected_readings [$];
  int errors = 0;
  int burst_left = 0;
  int n_readings = 0;
  int n_hits = 0;
  int n_flat = 0;
  int n_sweeps = 0;
  int n_saturated = 0;
  int n_negative = 0;

  function automatic void restore_calibration();
    for (int k = 0; k < CHANNELS; k++) begin
      cal_min[k] = MIN_RESET;
      cal_max[k] = MAX_RESET;
    end
  endfunction

  function automatic reading_t map_sample(input logic [ACT_W-1:0] act,
                                          input logic [CHAN_W-1:0] chan,
                                          input logic [SAMPLE_W-1:0] sample,
                                          input logic tail);
    reading_t r;
    int lo;
    int hi;
    int mapped;
    r = '0;
    if (act == ACT_CALIBRATE) begin
      if (sample < cal_min[chan]) cal_min[chan] = {1'b0, sample};
      if (sample > cal_max[chan]) cal_max[chan] = sample;
    end else if (act == ACT_CLEAR) begin
      restore_calibration();
    end else if (act == ACT_MEASURE) begin
      lo = int'(cal_min[chan]);
      hi = int'(cal_max[chan]);
      if (hi == lo) begin
        r.zero_span = 1'b1;
      end else begin
        mapped = ((int'(sample) - lo) * int'(MAP_TOP)) / (hi - lo);
        r.mapped_value = mapped[MAP_W-1:0];
        if (mapped > int'(line_thr)) begin
          r.on_line = 1'b1;
          if (sweep_total != COUNT_LIMIT) sweep_total = sweep_total + 1'b1;
        end
      end
      r.sweep_done = tail;
    end
    r.line_count = sweep_total;
    if (r.sweep_done) sweep_total = '0;
    return r;
  endfunction

  // one request with bursty valid; expectation queued on accept
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [CHAN_W-1:0] chan,
                              input logic [SAMPLE_W-1:0] sample, input logic tail,
                              input logic typed, input reading_t want);
    reading_t r;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, sample, chan};
    s_tuser <= act;
    s_tlast <= tail;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    r = map_sample(act, chan, sample, tail);
    expected_readings.push_back(typed ? want : r);
  endtask

  task automatic drain_readings();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_THRESHOLD, 2'b00};
    pwdata <= {22'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    line_thr = value;
  endtask

  function automatic logic [SAMPLE_W-1:0] cal_sample(input logic [SAMPLE_W-1:0] center);
    int v;
    if ($urandom_range(0, 2) != 0) return SAMPLE_W'($urandom_range(0, 1023));
    v = int'(center) + int'($urandom_range(0, 6)) - 3;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return v[SAMPLE_W-1:0];
  endfunction

  // occasional clears, calibration bursts followed by sweeps of measures, with some noise
  task automatic run_sweeps(input int quota);
    int sent;
    int n;
    logic [SAMPLE_W-1:0] center;
    logic [ACT_W-1:0] noise_act;
    logic tail;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 7) == 0) begin
        send_request(ACT_CLEAR, CHAN_W'($urandom_range(0, 15)),
                     SAMPLE_W'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
      center = SAMPLE_W'($urandom_range(0, 1023));
      n = $urandom_range(0, 8);
      for (int k = 0; k < n; k++) begin
        send_request(ACT_CALIBRATE, CHAN_W'($urandom_range(0, 15)), cal_sample(center),
                     1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(32, 48) : $urandom_range(1, 16);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 15) == 0) begin
          noise_act = ($urandom_range(0, 1) == 0) ? ACT_UNUSED : ACT_CALIBRATE;
          send_request(noise_act, CHAN_W'($urandom_range(0, 15)),
                       SAMPLE_W'($urandom_range(0, 1023)),
                       1'($urandom_range(0, 1)), 1'b0, '0);
          sent++;
        end
        if (k == n - 1) tail = ($urandom_range(0, 9) != 0);
        else tail = ($urandom_range(0, 19) == 0);
        send_request(ACT_MEASURE, CHAN_W'($urandom_range(0, 15)),
                     SAMPLE_W'($urandom_range(0, 1023)), tail, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // receiver stall pattern, mode picked anew at random each time the 8-bit phase counter wraps
  logic [7:0] stall_phase = '0;
  logic [1:0] stall_mode = '0;

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == 8'hff) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: begin
        m_tready <= 1'b1;
      end
      2'd1: begin
        m_tready <= ($urandom_range(0, 1) == 0);
      end
      2'd2: begin
        m_tready <= (stall_phase[2:0] < 3'd5);
      end
      default: begin
        m_tready <= (stall_phase[4:0] > 5'd20);
      end
    endcase
  end

  always @(posedge clk) begin : check_readings
    reading_t got;
    reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[20:0], m_tdata[21], m_tdata[26:22], m_tlast, m_tuser};
      if (expected_readings.size() == 0) begin
        errors++;
        $display("%0t unexpected reading %h", $time, got);
      end else begin
        want = expected_readings.pop_front();
        n_readings++;
        if (want.on_line) n_hits++;
        if (want.zero_span) n_flat++;
        if (want.sweep_done) n_sweeps++;
        if (want.line_count == COUNT_LIMIT) n_saturated++;
        if (want.mapped_value[MAP_W-1]) n_negative++;
        if (got.mapped_value !== want.mapped_value) begin
          errors++;
          $display("%0t mapped_value expected %0d actual %0d", $time,
                   $signed(want.mapped_value), $signed(got.mapped_value));
        end
        if (got.on_line !== want.on_line) begin
          errors++;
          $display("%0t on_line expected %b actual %b", $time, want.on_line, got.on_line);
        end
        if (got.line_count !== want.line_count) begin
          errors++;
          $display("%0t line_count expected %0d actual %0d", $time,
                   want.line_count, got.line_count);
        end
        if (got.sweep_done !== want.sweep_done) begin
          errors++;
          $display("%0t sweep_done expected %b actual %b", $time,
                   want.sweep_done, got.sweep_done);
        end
        if (got.zero_span !== want.zero_span) begin
          errors++;
          $display("%0t zero_span expected %b actual %b", $time,
                   want.zero_span, got.zero_span);
        end
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t timeout, %0d readings outstanding", $time, expected_readings.size());
      $display("FAIL line_sensor_calibrate_count");
      $finish;
    end
  end

  initial begin
    logic [THR_W-1:0] thresholds [5];
    line_thr = THRESHOLD_RESET;
    restore_calibration();
    sweep_total = '0;
    thresholds[0] = '0;
    thresholds[1] = 10'd1023;
    thresholds[2] = THR_W'($urandom_range(1, 1022));
    thresholds[3] = 10'd1;
    thresholds[4] = THR_W'($urandom_range(0, 1023));

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].act, DIRECTED_ROWS[i].chan, DIRECTED_ROWS[i].sample,
                   DIRECTED_ROWS[i].tail, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    end

    foreach (thresholds[p]) begin
      drain_readings();
      write_threshold(thresholds[p]);
      run_sweeps(PHASE_ITEMS);
    end

    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("checked %0d readings over 6 threshold settings: %0d on line, %0d zero span,",
             n_readings, n_hits, n_flat);
    $display("%0d negative maps, %0d sweep ends, %0d saturated counts",
             n_negative, n_sweeps, n_saturated);
    if (errors == 0 && expected_readings.size() == 0) begin
      $display("PASS line_sensor_calibrate_count");
    end else begin
      $display("FAIL line_sensor_calibrate_count");
    end
    $finish;
  end

endmodule

### line_sensor_calibrate_count.f
hw/rtl/lscc_pkg.sv
hw/rtl/lscc_div.sv
hw/rtl/line_sensor_calibrate_count.sv
tb/sv/testbench.sv
